// ----- src/scx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scx_pkg
// Shared widths, status codes and the pipeline payload type for the segment
// crossing test.
// ----------------------------------------------------------------------------
package scx_pkg;

    localparam int COORD_BITS   = 24;
    localparam int NODE_ID_BITS = 20;
    localparam int T_FRAC_BITS  = 32;
    localparam int MARGIN_BITS  = 16;
    localparam int PT_FRAC      = 16;
    localparam int PT_BITS      = 40;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int REM_W  = NUM_W + 1;
    localparam int PMUL_W = T_FRAC_BITS + 1 + DIFF_W;

    typedef enum logic [1:0] {
        ST_CROSS    = 2'd0,
        ST_SHARED   = 2'd1,
        ST_PARALLEL = 2'd2,
        ST_OUTSIDE  = 2'd3
    } status_t;

    // Data that rides alongside the division.
    typedef struct packed {
        status_t                        status;
        logic signed [COORD_BITS-1:0]   ax;
        logic signed [COORD_BITS-1:0]   ay;
        logic signed [DIFF_W-1:0]       rx;
        logic signed [DIFF_W-1:0]       ry;
    } side_t;

endpackage

// ----- src/scx_setup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scx_setup
// Four stages: endpoint check and differences, cross products, numerator and
// denominator sums, sign normalization and range check.
// ----------------------------------------------------------------------------
module scx_setup
    import scx_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [NODE_ID_BITS-1:0]         first_start_node,
    input  logic [NODE_ID_BITS-1:0]         first_end_node,
    input  logic [NODE_ID_BITS-1:0]         second_start_node,
    input  logic [NODE_ID_BITS-1:0]         second_end_node,
    input  logic signed [COORD_BITS-1:0]    ax,
    input  logic signed [COORD_BITS-1:0]    ay,
    input  logic signed [COORD_BITS-1:0]    bx,
    input  logic signed [COORD_BITS-1:0]    by_coord,
    input  logic signed [COORD_BITS-1:0]    cx,
    input  logic signed [COORD_BITS-1:0]    cy,
    input  logic signed [COORD_BITS-1:0]    dx,
    input  logic signed [COORD_BITS-1:0]    dy,
    output logic                            d_valid,
    output logic [NUM_W-1:0]                d_den,
    output logic [NUM_W-1:0]                d_n1,
    output logic [NUM_W-1:0]                d_n2,
    output side_t                           d_side
);

    logic                       a_valid_reg;
    side_t                      a_side_reg;
    logic signed [DIFF_W-1:0]   sx_reg, sy_reg, qx_reg, qy_reg;
    logic                       b_valid_reg;
    side_t                      b_side_reg;
    logic signed [PROD_W-1:0]   p_rs_reg, p_rs2_reg, p_n1a_reg, p_n1b_reg;
    logic signed [PROD_W-1:0]   p_n2a_reg, p_n2b_reg;
    logic                       c_valid_reg;
    side_t                      c_side_reg;
    logic signed [NUM_W-1:0]    den_reg, n1_reg, n2_reg;
    logic                       d_valid_reg;
    side_t                      d_side_reg;
    logic [NUM_W-1:0]           den_abs_reg, n1_abs_reg, n2_abs_reg;

    side_t                      a_side_next;
    side_t                      d_side_next;
    logic signed [NUM_W-1:0]    den_abs_next, n1_abs_next, n2_abs_next;
    logic                       shared;

    always_comb
    begin
        shared = (first_start_node == second_start_node) ||
                 (first_start_node == second_end_node) ||
                 (first_end_node == second_start_node) ||
                 (first_end_node == second_end_node);
        a_side_next.status = shared ? ST_SHARED : ST_CROSS;
        a_side_next.ax = ax;
        a_side_next.ay = ay;
        a_side_next.rx = {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
        a_side_next.ry = {by_coord[COORD_BITS-1], by_coord} - {ay[COORD_BITS-1], ay};
    end

    always_comb
    begin
        d_side_next = c_side_reg;
        if (den_reg[NUM_W-1])
        begin
            den_abs_next = -den_reg;
            n1_abs_next  = -n1_reg;
            n2_abs_next  = -n2_reg;
        end
        else
        begin
            den_abs_next = den_reg;
            n1_abs_next  = n1_reg;
            n2_abs_next  = n2_reg;
        end
        if (c_side_reg.status == ST_CROSS)
        begin
            if (den_reg == '0)
            begin
                d_side_next.status = ST_PARALLEL;
            end
            else if (n1_abs_next[NUM_W-1] || n2_abs_next[NUM_W-1] ||
                     !(n1_abs_next < den_abs_next) || !(n2_abs_next < den_abs_next))
            begin
                d_side_next.status = ST_OUTSIDE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg  <= a_side_next;
            sx_reg      <= {dx[COORD_BITS-1], dx} - {cx[COORD_BITS-1], cx};
            sy_reg      <= {dy[COORD_BITS-1], dy} - {cy[COORD_BITS-1], cy};
            qx_reg      <= {cx[COORD_BITS-1], cx} - {ax[COORD_BITS-1], ax};
            qy_reg      <= {cy[COORD_BITS-1], cy} - {ay[COORD_BITS-1], ay};

            b_side_reg  <= a_side_reg;
            p_rs_reg    <= a_side_reg.rx * sy_reg;
            p_rs2_reg   <= a_side_reg.ry * sx_reg;
            p_n1a_reg   <= qx_reg * sy_reg;
            p_n1b_reg   <= qy_reg * sx_reg;
            p_n2a_reg   <= qx_reg * a_side_reg.ry;
            p_n2b_reg   <= qy_reg * a_side_reg.rx;

            c_side_reg  <= b_side_reg;
            den_reg     <= {p_rs_reg[PROD_W-1], p_rs_reg} - {p_rs2_reg[PROD_W-1], p_rs2_reg};
            n1_reg      <= {p_n1a_reg[PROD_W-1], p_n1a_reg} - {p_n1b_reg[PROD_W-1], p_n1b_reg};
            n2_reg      <= {p_n2a_reg[PROD_W-1], p_n2a_reg} - {p_n2b_reg[PROD_W-1], p_n2b_reg};

            d_side_reg  <= d_side_next;
            den_abs_reg <= den_abs_next;
            n1_abs_reg  <= n1_abs_next;
            n2_abs_reg  <= n2_abs_next;
        end
    end

    assign d_valid = d_valid_reg;
    assign d_den   = den_abs_reg;
    assign d_n1    = n1_abs_reg;
    assign d_n2    = n2_abs_reg;
    assign d_side  = d_side_reg;

endmodule

// ----- src/scx_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scx_divider
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing
// one denominator.
// ----------------------------------------------------------------------------
module scx_divider
    import scx_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [NUM_W-1:0]            den,
    input  logic [NUM_W-1:0]            n1,
    input  logic [NUM_W-1:0]            n2,
    input  side_t                       side_in,
    output logic                        out_valid,
    output logic [T_FRAC_BITS-1:0]      q1,
    output logic [T_FRAC_BITS-1:0]      q2,
    output side_t                       side_out
);

    logic                       valid_reg [T_FRAC_BITS];
    logic [NUM_W-1:0]           den_reg   [T_FRAC_BITS];
    logic [REM_W-1:0]           rem1_reg  [T_FRAC_BITS];
    logic [REM_W-1:0]           rem2_reg  [T_FRAC_BITS];
    logic [T_FRAC_BITS-1:0]     q1_reg    [T_FRAC_BITS];
    logic [T_FRAC_BITS-1:0]     q2_reg    [T_FRAC_BITS];
    side_t                      side_reg  [T_FRAC_BITS];

    logic [REM_W-1:0]           rem1_in   [T_FRAC_BITS];
    logic [REM_W-1:0]           rem2_in   [T_FRAC_BITS];
    logic [T_FRAC_BITS-1:0]     q1_in     [T_FRAC_BITS];
    logic [T_FRAC_BITS-1:0]     q2_in     [T_FRAC_BITS];
    logic [NUM_W-1:0]           den_in    [T_FRAC_BITS];
    logic                       valid_in  [T_FRAC_BITS];
    side_t                      side_in_s [T_FRAC_BITS];
    logic [REM_W-1:0]           rem1_next [T_FRAC_BITS];
    logic [REM_W-1:0]           rem2_next [T_FRAC_BITS];
    logic [T_FRAC_BITS-1:0]     q1_next   [T_FRAC_BITS];
    logic [T_FRAC_BITS-1:0]     q2_next   [T_FRAC_BITS];

    always_comb
    begin
        rem1_in[0]   = {1'b0, n1};
        rem2_in[0]   = {1'b0, n2};
        q1_in[0]     = '0;
        q2_in[0]     = '0;
        den_in[0]    = den;
        valid_in[0]  = in_valid;
        side_in_s[0] = side_in;
        for (int k = 1; k < T_FRAC_BITS; k++)
        begin
            rem1_in[k]   = rem1_reg[k-1];
            rem2_in[k]   = rem2_reg[k-1];
            q1_in[k]     = q1_reg[k-1];
            q2_in[k]     = q2_reg[k-1];
            den_in[k]    = den_reg[k-1];
            valid_in[k]  = valid_reg[k-1];
            side_in_s[k] = side_reg[k-1];
        end
    end

    // The remainder stays below the denominator, so the doubled value fits.
    always_comb
    begin
        for (int k = 0; k < T_FRAC_BITS; k++)
        begin
            logic [REM_W-1:0] sh1;
            logic [REM_W-1:0] sh2;
            logic [REM_W-1:0] dext;
            sh1  = {rem1_in[k][REM_W-2:0], 1'b0};
            sh2  = {rem2_in[k][REM_W-2:0], 1'b0};
            dext = {1'b0, den_in[k]};
            if (sh1 >= dext)
            begin
                rem1_next[k] = sh1 - dext;
                q1_next[k]   = {q1_in[k][T_FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem1_next[k] = sh1;
                q1_next[k]   = {q1_in[k][T_FRAC_BITS-2:0], 1'b0};
            end
            if (sh2 >= dext)
            begin
                rem2_next[k] = sh2 - dext;
                q2_next[k]   = {q2_in[k][T_FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem2_next[k] = sh2;
                q2_next[k]   = {q2_in[k][T_FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < T_FRAC_BITS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < T_FRAC_BITS; k++)
            begin
                valid_reg[k] <= valid_in[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < T_FRAC_BITS; k++)
            begin
                den_reg[k]  <= den_in[k];
                side_reg[k] <= side_in_s[k];
                rem1_reg[k] <= rem1_next[k];
                rem2_reg[k] <= rem2_next[k];
                q1_reg[k]   <= q1_next[k];
                q2_reg[k]   <= q2_next[k];
            end
        end
    end

    assign out_valid = valid_reg[T_FRAC_BITS-1];
    assign q1        = q1_reg[T_FRAC_BITS-1];
    assign q2        = q2_reg[T_FRAC_BITS-1];
    assign side_out  = side_reg[T_FRAC_BITS-1];

endmodule

// ----- src/scx_point.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scx_point
// Margin check on both parameters, crossing point multiply, and the output
// register.
// ----------------------------------------------------------------------------
module scx_point
    import scx_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [MARGIN_BITS-1:0]      margin,
    input  logic                        in_valid,
    input  logic [T_FRAC_BITS-1:0]      q1,
    input  logic [T_FRAC_BITS-1:0]      q2,
    input  side_t                       side_in,
    output logic                        out_valid,
    output logic [1:0]                  status,
    output logic signed [PT_BITS-1:0]   cross_x,
    output logic signed [PT_BITS-1:0]   cross_y,
    output logic [T_FRAC_BITS-1:0]      t_first,
    output logic [T_FRAC_BITS-1:0]      t_second
);

    logic                           m_valid_reg;
    status_t                        m_status_reg;
    logic [T_FRAC_BITS-1:0]         m_t1_reg, m_t2_reg;
    logic signed [COORD_BITS-1:0]   m_ax_reg, m_ay_reg;
    logic signed [PMUL_W-1:0]       m_px_reg, m_py_reg;

    logic                           o_valid_reg;
    status_t                        o_status_reg;
    logic signed [PT_BITS-1:0]      o_x_reg, o_y_reg;
    logic [T_FRAC_BITS-1:0]         o_t1_reg, o_t2_reg;

    status_t                        m_status_next;
    logic [T_FRAC_BITS:0]           upper;
    logic                           ok1, ok2;
    logic signed [PMUL_W-1:0]       sx_shift, sy_shift;
    logic signed [PT_BITS-1:0]      x_next, y_next;

    always_comb
    begin
        upper = (T_FRAC_BITS+1)'(1) << T_FRAC_BITS;
        upper = upper - (T_FRAC_BITS+1)'(margin);
        ok1 = (q1 > T_FRAC_BITS'(margin)) && ({1'b0, q1} < upper);
        ok2 = (q2 > T_FRAC_BITS'(margin)) && ({1'b0, q2} < upper);
        m_status_next = side_in.status;
        if (side_in.status == ST_CROSS && !(ok1 && ok2))
        begin
            m_status_next = ST_OUTSIDE;
        end
    end

    always_comb
    begin
        sx_shift = m_px_reg >>> (T_FRAC_BITS - PT_FRAC);
        sy_shift = m_py_reg >>> (T_FRAC_BITS - PT_FRAC);
        x_next = PT_BITS'(sx_shift) + (PT_BITS'(m_ax_reg) << PT_FRAC);
        y_next = PT_BITS'(sy_shift) + (PT_BITS'(m_ay_reg) << PT_FRAC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= in_valid;
            o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_status_reg <= m_status_next;
            m_t1_reg     <= q1;
            m_t2_reg     <= q2;
            m_ax_reg     <= side_in.ax;
            m_ay_reg     <= side_in.ay;
            m_px_reg     <= $signed({1'b0, q1}) * side_in.rx;
            m_py_reg     <= $signed({1'b0, q1}) * side_in.ry;

            o_status_reg <= m_status_reg;
            if (m_status_reg == ST_CROSS)
            begin
                o_x_reg  <= x_next;
                o_y_reg  <= y_next;
                o_t1_reg <= m_t1_reg;
                o_t2_reg <= m_t2_reg;
            end
            else
            begin
                o_x_reg  <= '0;
                o_y_reg  <= '0;
                o_t1_reg <= '0;
                o_t2_reg <= '0;
            end
        end
    end

    assign out_valid = o_valid_reg;
    assign status    = o_status_reg;
    assign cross_x   = o_x_reg;
    assign cross_y   = o_y_reg;
    assign t_first   = o_t1_reg;
    assign t_second  = o_t2_reg;

endmodule

// ----- src/segment_crossing_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_crossing_test
// Strict interior crossing test for one pair of straight edges per item.
// ----------------------------------------------------------------------------
// Pipeline: 4 setup stages, 32 divider stages, margin/multiply stage and
// output register. Throughput: one item per cycle; the whole pipeline holds
// while a result waits under stall. Reset clears all valid bits and sets
// t_margin to 4.
module segment_crossing_test
    import scx_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [MARGIN_BITS-1:0]          cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [NODE_ID_BITS-1:0]         first_start_node,
    input  logic [NODE_ID_BITS-1:0]         first_end_node,
    input  logic [NODE_ID_BITS-1:0]         second_start_node,
    input  logic [NODE_ID_BITS-1:0]         second_end_node,
    input  logic signed [COORD_BITS-1:0]    ax,
    input  logic signed [COORD_BITS-1:0]    ay,
    input  logic signed [COORD_BITS-1:0]    bx,
    input  logic signed [COORD_BITS-1:0]    by_coord,
    input  logic signed [COORD_BITS-1:0]    cx,
    input  logic signed [COORD_BITS-1:0]    cy,
    input  logic signed [COORD_BITS-1:0]    dx,
    input  logic signed [COORD_BITS-1:0]    dy,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic signed [PT_BITS-1:0]       cross_x,
    output logic signed [PT_BITS-1:0]       cross_y,
    output logic [T_FRAC_BITS-1:0]          t_first,
    output logic [T_FRAC_BITS-1:0]          t_second
);

    logic [MARGIN_BITS-1:0]     t_margin_reg;
    logic                       en;
    logic                       d_valid;
    logic [NUM_W-1:0]           d_den, d_n1, d_n2;
    side_t                      d_side;
    logic                       q_valid;
    logic [T_FRAC_BITS-1:0]     q1, q2;
    side_t                      q_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_margin_reg <= MARGIN_BITS'(4);
        end
        else if (cfg_we)
        begin
            t_margin_reg <= cfg_wdata;
        end
    end

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    scx_setup u_setup (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in_valid          (in_valid),
        .first_start_node  (first_start_node),
        .first_end_node    (first_end_node),
        .second_start_node (second_start_node),
        .second_end_node   (second_end_node),
        .ax                (ax),
        .ay                (ay),
        .bx                (bx),
        .by_coord          (by_coord),
        .cx                (cx),
        .cy                (cy),
        .dx                (dx),
        .dy                (dy),
        .d_valid           (d_valid),
        .d_den             (d_den),
        .d_n1              (d_n1),
        .d_n2              (d_n2),
        .d_side            (d_side)
    );

    scx_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .den       (d_den),
        .n1        (d_n1),
        .n2        (d_n2),
        .side_in   (d_side),
        .out_valid (q_valid),
        .q1        (q1),
        .q2        (q2),
        .side_out  (q_side)
    );

    scx_point u_point (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .margin    (t_margin_reg),
        .in_valid  (q_valid),
        .q1        (q1),
        .q2        (q2),
        .side_in   (q_side),
        .out_valid (out_valid),
        .status    (status),
        .cross_x   (cross_x),
        .cross_y   (cross_y),
        .t_first   (t_first),
        .t_second  (t_second)
    );

endmodule

// ----- src/scx_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scx_checker
// Port-level checks for the segment crossing test, bound to the top level.
// ----------------------------------------------------------------------------
module scx_checker
    import scx_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [1:0]                  status,
    input  logic signed [PT_BITS-1:0]   cross_x,
    input  logic signed [PT_BITS-1:0]   cross_y,
    input  logic [T_FRAC_BITS-1:0]      t_first,
    input  logic [T_FRAC_BITS-1:0]      t_second
);

    // A rejected pair carries no point and no parameters.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_CROSS) |->
        (cross_x == '0 && cross_y == '0 && t_first == '0 && t_second == '0))
        else $error("rejected item has nonzero payload");

    // A crossing lies strictly inside both segments.
    a_cross_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_CROSS) |-> (t_first != '0 && t_second != '0))
        else $error("crossing with zero parameter");

    // The input side only backs up when a result is held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) &&
        $stable(cross_x) && $stable(t_first) && $stable(t_second)))
        else $error("stalled result changed");

endmodule

bind segment_crossing_test scx_checker u_scx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cross_x   (cross_x),
    .cross_y   (cross_y),
    .t_first   (t_first),
    .t_second  (t_second)
);
